FILE: hdl/rmstat_pkg.sv
// ----------------------------------------------------------------------------
// rmstat_pkg
// Shared constants and types for the running metric statistics core.
// ----------------------------------------------------------------------------
package rmstat_pkg;

   localparam int ID_BITS       = 32;
   localparam int LOC_BITS      = 32;
   localparam int THRESH_BITS   = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int SQ_SUM_BITS   = 64;
   localparam int RMS_BITS      = 31;
   localparam int FRAC_BITS     = 16;
   localparam int SUM_EXTRA     = 16;
   localparam int SQ_SAT_BIT    = 40;
   localparam int MS_SAT_BIT    = 46;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LARGEST_IS_WORST  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WARNING_ENABLE    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WARNING_THRESHOLD = 2'd2;

   typedef struct packed {
      logic                   largest_is_worst;
      logic                   warning_enable;
      logic [THRESH_BITS-1:0] warning_threshold;
   } cfg_type;

endpackage

FILE: hdl/rmstat_queue.sv
// ----------------------------------------------------------------------------
// rmstat_queue
// Two-entry transaction queue between the front and the back.
// ----------------------------------------------------------------------------
module rmstat_queue #(
   parameter int WIDTH = 162
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/rmstat_front.sv
// ----------------------------------------------------------------------------
// rmstat_front
// Register file, request intake and threshold classification.
// ----------------------------------------------------------------------------
module rmstat_front #(
   parameter int VALUE_BITS = 32,
   parameter int ITEM_BITS  = 162
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [rmstat_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rmstat_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [VALUE_BITS-1:0]                 req_sample_value,
   input  logic [rmstat_pkg::ID_BITS-1:0]        req_entity_id,
   input  logic [rmstat_pkg::LOC_BITS-1:0]       req_loc_x,
   input  logic [rmstat_pkg::LOC_BITS-1:0]       req_loc_y,
   input  logic [rmstat_pkg::LOC_BITS-1:0]       req_loc_z,
   input  logic                                  req_last_sample,
   input  logic                                  q_full,
   output logic                                  q_push,
   output logic [ITEM_BITS-1:0]                  q_data,
   output rmstat_pkg::cfg_type                   cfg
);

   localparam int CMP_BITS = 49;

   rmstat_pkg::cfg_type cfg_ff, cfg_in;
   logic signed [CMP_BITS-1:0] value_ext;
   logic signed [CMP_BITS-1:0] thresh_ext;
   logic                       above;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rmstat_pkg::CSR_LARGEST_IS_WORST:  cfg_in.largest_is_worst = csr_wdata[0];
            rmstat_pkg::CSR_WARNING_ENABLE:    cfg_in.warning_enable   = csr_wdata[0];
            rmstat_pkg::CSR_WARNING_THRESHOLD:
               cfg_in.warning_threshold = csr_wdata[rmstat_pkg::THRESH_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // classify: strictly above the warning limit
   assign value_ext  = CMP_BITS'($signed(req_sample_value));
   assign thresh_ext = CMP_BITS'($signed(cfg_ff.warning_threshold));
   assign above      = cfg_ff.warning_enable && (value_ext > thresh_ext);

   assign req_ready = ~q_full;
   assign q_push    = req_valid & ~q_full;
   assign q_data    = {req_last_sample, above, req_loc_z, req_loc_y, req_loc_x,
                       req_entity_id, req_sample_value};

endmodule

FILE: hdl/rmstat_back.sv
// ----------------------------------------------------------------------------
// rmstat_back
// Run accumulation, shared radix-2 divider, square root and result register.
// ----------------------------------------------------------------------------
module rmstat_back #(
   parameter int COUNT_BITS = 16,
   parameter int VALUE_BITS = 32,
   parameter int ITEM_BITS  = 162
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmstat_pkg::cfg_type                  cfg,
   input  logic                                 q_valid,
   input  logic [ITEM_BITS-1:0]                 q_data,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [COUNT_BITS-1:0]                rsp_sample_count,
   output logic [VALUE_BITS-1:0]                rsp_min_value,
   output logic [VALUE_BITS-1:0]                rsp_max_value,
   output logic [rmstat_pkg::ID_BITS-1:0]       rsp_worst_entity,
   output logic [rmstat_pkg::LOC_BITS-1:0]      rsp_worst_x,
   output logic [rmstat_pkg::LOC_BITS-1:0]      rsp_worst_y,
   output logic [rmstat_pkg::LOC_BITS-1:0]      rsp_worst_z,
   output logic [COUNT_BITS-1:0]                rsp_above_count,
   output logic [VALUE_BITS-1:0]                rsp_mean_value,
   output logic [rmstat_pkg::RMS_BITS-1:0]      rsp_rms_value
);

   localparam int SB    = VALUE_BITS + rmstat_pkg::SUM_EXTRA;
   localparam int QB    = rmstat_pkg::SQ_SUM_BITS;
   localparam int RB    = rmstat_pkg::RMS_BITS;
   localparam int LB    = rmstat_pkg::LOC_BITS;
   localparam int IB    = rmstat_pkg::ID_BITS;
   localparam int PB    = 2 * VALUE_BITS + QB;
   localparam int ID_LO = VALUE_BITS;
   localparam int X_LO  = ID_LO + IB;
   localparam int Y_LO  = X_LO + LB;
   localparam int Z_LO  = Y_LO + LB;
   localparam int AB_BIT = Z_LO + LB;
   localparam int LS_BIT = AB_BIT + 1;
   localparam logic [QB-1:0] MAG_LIM = QB'(1) << (VALUE_BITS - 1);
   localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [SB-1:0] SUM_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic [SB-1:0] SUM_MIN = {1'b1, {(SB-1){1'b0}}};
   localparam logic [5:0] DIV_LAST  = 6'd63;
   localparam logic [5:0] SQRT_LAST = 6'(RB - 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ACC     = 3'd1;
   localparam logic [2:0] ST_MEAN_LD = 3'd2;
   localparam logic [2:0] ST_MEAN    = 3'd3;
   localparam logic [2:0] ST_MS_LD   = 3'd4;
   localparam logic [2:0] ST_MS      = 3'd5;
   localparam logic [2:0] ST_SQRT    = 3'd6;
   localparam logic [2:0] ST_OUT     = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [ITEM_BITS-1:0]   work_ff, work_in;
   logic [QB-1:0]          sq_ff, sq_in;

   logic [COUNT_BITS-1:0]  run_count_ff, run_count_in;
   logic [VALUE_BITS-1:0]  run_min_ff, run_min_in;
   logic [VALUE_BITS-1:0]  run_max_ff, run_max_in;
   logic [IB-1:0]          worst_id_ff, worst_id_in;
   logic [LB-1:0]          worst_x_ff, worst_x_in;
   logic [LB-1:0]          worst_y_ff, worst_y_in;
   logic [LB-1:0]          worst_z_ff, worst_z_in;
   logic [SB-1:0]          value_sum_ff, value_sum_in;
   logic [QB-1:0]          square_sum_ff, square_sum_in;
   logic [COUNT_BITS-1:0]  hits_ff, hits_in;

   logic [COUNT_BITS:0]    div_rem_ff, div_rem_in;
   logic [QB-1:0]          div_quo_ff, div_quo_in;
   logic [5:0]             step_ff, step_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_BITS-1:0]  mean_ff, mean_in;
   logic                   rms_sat_ff, rms_sat_in;
   logic [2*RB-1:0]        rad_ff, rad_in;
   logic [RB+2:0]          sq_rem_ff, sq_rem_in;
   logic [RB-1:0]          root_ff, root_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_load;
   logic [COUNT_BITS-1:0]  o_count_ff, o_hits_ff;
   logic [VALUE_BITS-1:0]  o_min_ff, o_max_ff, o_mean_ff;
   logic [IB-1:0]          o_id_ff;
   logic [LB-1:0]          o_x_ff, o_y_ff, o_z_ff;
   logic [RB-1:0]          o_rms_ff;

   // item fields
   logic [VALUE_BITS-1:0]  q_v, w_v, q_abs;
   logic [PB-1:0]          q_prod;
   logic                   q_big;
   logic                   first, take, v_lt_min, v_gt_max;
   logic [SB:0]            sum_wide;
   logic [QB:0]            sq_wide;
   logic [SB-1:0]          sum_abs;
   logic [COUNT_BITS:0]    rem_sh, rem_sub;
   logic                   rem_ge;
   logic [RB+2:0]          srem_sh, srem_trial;
   logic                   srem_ge;

   always_comb begin
      q_v    = q_data[VALUE_BITS-1:0];
      w_v    = work_ff[VALUE_BITS-1:0];
      q_abs  = q_v[VALUE_BITS-1] ? (~q_v + 1'b1) : q_v;
      q_prod = PB'(q_abs) * PB'(q_abs);
      q_big  = (PB'(q_abs) >> rmstat_pkg::SQ_SAT_BIT) != '0;

      first    = (run_count_ff == '0);
      v_lt_min = $signed(w_v) < $signed(run_min_ff);
      v_gt_max = $signed(w_v) > $signed(run_max_ff);
      take     = first || (cfg.largest_is_worst ? v_gt_max : v_lt_min);

      sum_wide = {value_sum_ff[SB-1], value_sum_ff}
               + (SB+1)'($signed(w_v));
      sq_wide  = {1'b0, square_sum_ff} + {1'b0, sq_ff};
      sum_abs  = value_sum_ff[SB-1] ? (~value_sum_ff + 1'b1) : value_sum_ff;

      rem_sh  = {div_rem_ff[COUNT_BITS-1:0], div_quo_ff[QB-1]};
      rem_ge  = rem_sh >= {1'b0, run_count_ff};
      rem_sub = rem_sh - {1'b0, run_count_ff};

      srem_sh    = {sq_rem_ff[RB:0], rad_ff[2*RB-1 -: 2]};
      srem_trial = {1'b0, root_ff, 2'b01};
      srem_ge    = srem_sh >= srem_trial;
   end

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      sq_in         = sq_ff;
      run_count_in  = run_count_ff;
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      worst_id_in   = worst_id_ff;
      worst_x_in    = worst_x_ff;
      worst_y_in    = worst_y_ff;
      worst_z_in    = worst_z_ff;
      value_sum_in  = value_sum_ff;
      square_sum_in = square_sum_ff;
      hits_in       = hits_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      mean_in       = mean_ff;
      rms_sat_in    = rms_sat_ff;
      rad_in        = rad_ff;
      sq_rem_in     = sq_rem_ff;
      root_in       = root_ff;
      q_pop         = 1'b0;
      out_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               work_in  = q_data;
               sq_in    = q_big ? '1 : q_prod[QB+rmstat_pkg::FRAC_BITS-1:rmstat_pkg::FRAC_BITS];
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            run_min_in = (first || v_lt_min) ? w_v : run_min_ff;
            run_max_in = (first || v_gt_max) ? w_v : run_max_ff;
            if (take) begin
               worst_id_in = work_ff[ID_LO +: IB];
               worst_x_in  = work_ff[X_LO +: LB];
               worst_y_in  = work_ff[Y_LO +: LB];
               worst_z_in  = work_ff[Z_LO +: LB];
            end
            if (run_count_ff != '1) begin
               run_count_in = run_count_ff + 1'b1;
            end
            if (sum_wide[SB] != sum_wide[SB-1]) begin
               value_sum_in = sum_wide[SB] ? SUM_MIN : SUM_MAX;
            end else begin
               value_sum_in = sum_wide[SB-1:0];
            end
            square_sum_in = sq_wide[QB] ? '1 : sq_wide[QB-1:0];
            if (work_ff[AB_BIT] && (hits_ff != '1)) begin
               hits_in = hits_ff + 1'b1;
            end
            state_in = work_ff[LS_BIT] ? ST_MEAN_LD : ST_IDLE;
         end
         ST_MEAN_LD: begin
            div_quo_in = QB'(sum_abs);
            div_rem_in = '0;
            step_in    = '0;
            neg_in     = value_sum_ff[SB-1];
            state_in   = ST_MEAN;
         end
         ST_MEAN, ST_MS: begin
            div_rem_in = rem_ge ? rem_sub : rem_sh;
            div_quo_in = {div_quo_ff[QB-2:0], rem_ge};
            step_in    = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = (state_ff == ST_MEAN) ? ST_MS_LD : ST_SQRT;
               if (state_ff == ST_MS) begin
                  rms_sat_in = (div_quo_in >> rmstat_pkg::MS_SAT_BIT) != '0;
                  rad_in     = {div_quo_in[2*RB-rmstat_pkg::FRAC_BITS-1:0],
                                {rmstat_pkg::FRAC_BITS{1'b0}}};
                  sq_rem_in  = '0;
                  root_in    = '0;
                  step_in    = '0;
               end
            end
         end
         ST_MS_LD: begin
            if (neg_ff) begin
               mean_in = (div_quo_ff > MAG_LIM) ? VAL_MIN
                       : (~div_quo_ff[VALUE_BITS-1:0] + 1'b1);
            end else begin
               mean_in = (div_quo_ff >= MAG_LIM) ? VAL_MAX : div_quo_ff[VALUE_BITS-1:0];
            end
            div_quo_in = square_sum_ff;
            div_rem_in = '0;
            step_in    = '0;
            state_in   = ST_MS;
         end
         ST_SQRT: begin
            sq_rem_in = srem_ge ? (srem_sh - srem_trial) : srem_sh;
            root_in   = {root_ff[RB-2:0], srem_ge};
            rad_in    = {rad_ff[2*RB-3:0], 2'b00};
            step_in   = step_ff + 1'b1;
            if (step_ff == SQRT_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               run_count_in  = '0;
               run_min_in    = '0;
               run_max_in    = '0;
               worst_id_in   = '0;
               worst_x_in    = '0;
               worst_y_in    = '0;
               worst_z_in    = '0;
               value_sum_in  = '0;
               square_sum_in = '0;
               hits_in       = '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         run_count_ff  <= '0;
         run_min_ff    <= '0;
         run_max_ff    <= '0;
         worst_id_ff   <= '0;
         worst_x_ff    <= '0;
         worst_y_ff    <= '0;
         worst_z_ff    <= '0;
         value_sum_ff  <= '0;
         square_sum_ff <= '0;
         hits_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         run_count_ff  <= run_count_in;
         run_min_ff    <= run_min_in;
         run_max_ff    <= run_max_in;
         worst_id_ff   <= worst_id_in;
         worst_x_ff    <= worst_x_in;
         worst_y_ff    <= worst_y_in;
         worst_z_ff    <= worst_z_in;
         value_sum_ff  <= value_sum_in;
         square_sum_ff <= square_sum_in;
         hits_ff       <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      sq_ff      <= sq_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      step_ff    <= step_in;
      neg_ff     <= neg_in;
      mean_ff    <= mean_in;
      rms_sat_ff <= rms_sat_in;
      rad_ff     <= rad_in;
      sq_rem_ff  <= sq_rem_in;
      root_ff    <= root_in;
      if (out_load) begin
         o_count_ff <= run_count_ff;
         o_min_ff   <= run_min_ff;
         o_max_ff   <= run_max_ff;
         o_id_ff    <= worst_id_ff;
         o_x_ff     <= worst_x_ff;
         o_y_ff     <= worst_y_ff;
         o_z_ff     <= worst_z_ff;
         o_hits_ff  <= hits_ff;
         o_mean_ff  <= mean_ff;
         o_rms_ff   <= rms_sat_ff ? '1 : root_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_count = o_count_ff;
   assign rsp_min_value    = o_min_ff;
   assign rsp_max_value    = o_max_ff;
   assign rsp_worst_entity = o_id_ff;
   assign rsp_worst_x      = o_x_ff;
   assign rsp_worst_y      = o_y_ff;
   assign rsp_worst_z      = o_z_ff;
   assign rsp_above_count  = o_hits_ff;
   assign rsp_mean_value   = o_mean_ff;
   assign rsp_rms_value    = o_rms_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("queue popped outside idle");

   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (run_count_ff != '0))
      else $error("result loaded for an empty run");

   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (run_count_ff == '0) && rsp_valid_ff)
      else $error("run not cleared after result");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (run_count_ff != '0) |-> ($signed(run_min_ff) <= $signed(run_max_ff)))
      else $error("run minimum above maximum");

endmodule

FILE: hdl/running_metric_statistics_core.sv
// ----------------------------------------------------------------------------
// running_metric_statistics_core
// Running count, min, max, worst item, above-threshold count, mean and rms of a metric stream.
// ----------------------------------------------------------------------------
// Each transaction passes through a two-entry queue into the accumulator, which
// handles it in two states (pop with squaring, then the update of the run
// totals) and pops the next one only after those totals are updated. On the
// transaction marked last the accumulator goes on through two 64-step
// radix-2 divisions by the count (mean, then mean square) with a load state
// ahead of each, a 31-step square root and a state that loads the output
// register once the previous result has been taken, after which the result
// sits there until taken while the next run is accumulated.
module running_metric_statistics_core #(
   parameter int COUNT_BITS = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rmstat_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rmstat_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [VALUE_BITS-1:0]                req_sample_value,
   input  logic [rmstat_pkg::ID_BITS-1:0]       req_entity_id,
   input  logic [rmstat_pkg::LOC_BITS-1:0]      req_loc_x,
   input  logic [rmstat_pkg::LOC_BITS-1:0]      req_loc_y,
   input  logic [rmstat_pkg::LOC_BITS-1:0]      req_loc_z,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [COUNT_BITS-1:0]                rsp_sample_count,
   output logic [VALUE_BITS-1:0]                rsp_min_value,
   output logic [VALUE_BITS-1:0]                rsp_max_value,
   output logic [rmstat_pkg::ID_BITS-1:0]       rsp_worst_entity,
   output logic [rmstat_pkg::LOC_BITS-1:0]      rsp_worst_x,
   output logic [rmstat_pkg::LOC_BITS-1:0]      rsp_worst_y,
   output logic [rmstat_pkg::LOC_BITS-1:0]      rsp_worst_z,
   output logic [COUNT_BITS-1:0]                rsp_above_count,
   output logic [VALUE_BITS-1:0]                rsp_mean_value,
   output logic [rmstat_pkg::RMS_BITS-1:0]      rsp_rms_value
);

   localparam int ITEM_BITS = VALUE_BITS + rmstat_pkg::ID_BITS
                            + 3 * rmstat_pkg::LOC_BITS + 2;

   rmstat_pkg::cfg_type  cfg;
   logic                 q_push, q_full, q_pop, q_valid;
   logic [ITEM_BITS-1:0] q_wdata, q_rdata;

   rmstat_front #(
      .VALUE_BITS (VALUE_BITS),
      .ITEM_BITS  (ITEM_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_entity_id    (req_entity_id),
      .req_loc_x        (req_loc_x),
      .req_loc_y        (req_loc_y),
      .req_loc_z        (req_loc_z),
      .req_last_sample  (req_last_sample),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_wdata),
      .cfg              (cfg)
   );

   rmstat_queue #(
      .WIDTH (ITEM_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_rdata)
   );

   rmstat_back #(
      .COUNT_BITS (COUNT_BITS),
      .VALUE_BITS (VALUE_BITS),
      .ITEM_BITS  (ITEM_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_valid          (q_valid),
      .q_data           (q_rdata),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_count (rsp_sample_count),
      .rsp_min_value    (rsp_min_value),
      .rsp_max_value    (rsp_max_value),
      .rsp_worst_entity (rsp_worst_entity),
      .rsp_worst_x      (rsp_worst_x),
      .rsp_worst_y      (rsp_worst_y),
      .rsp_worst_z      (rsp_worst_z),
      .rsp_above_count  (rsp_above_count),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_rms_value    (rsp_rms_value)
   );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives runs of metric transactions through the statistics core with random
// idling on both channels, predicts each run summary in a local model and
// compares every summary field by field, across several register settings.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CNT_MAX    = 65535;
   localparam int DRAIN_WAIT = 400;
   localparam int STALL_LIMIT = 20000;
   localparam logic [rmstat_pkg::CSR_IDX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic [31:0] value;
      logic [31:0] id;
      logic [31:0] lx;
      logic [31:0] ly;
      logic [31:0] lz;
      logic        last;
   } sample_type;

   typedef struct {
      logic [15:0] count;
      logic [31:0] min_v;
      logic [31:0] max_v;
      logic [31:0] worst_id;
      logic [31:0] wx;
      logic [31:0] wy;
      logic [31:0] wz;
      logic [15:0] above;
      logic [31:0] mean;
      logic [30:0] rms;
   } summary_type;

   typedef struct {
      sample_type  s;
      bit          known;
      summary_type sum;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [rmstat_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [rmstat_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_sample_value = '0;
   logic [31:0] req_entity_id = '0;
   logic [31:0] req_loc_x = '0;
   logic [31:0] req_loc_y = '0;
   logic [31:0] req_loc_z = '0;
   logic        req_last_sample = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_sample_count;
   logic [31:0] rsp_min_value, rsp_max_value, rsp_worst_entity;
   logic [31:0] rsp_worst_x, rsp_worst_y, rsp_worst_z;
   logic [15:0] rsp_above_count;
   logic [31:0] rsp_mean_value;
   logic [30:0] rsp_rms_value;

   running_metric_statistics_core i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   rmstat_pkg::cfg_type cfg;
   int unsigned    run_cnt;
   logic signed [31:0] run_lo, run_hi;
   logic [31:0]    w_id, w_x, w_y, w_z;
   logic signed [47:0] val_sum;
   logic [63:0]    sq_sum;
   int unsigned    hits;

   summary_type summary_queue[$];
   int          errors = 0;
   int          send_idle = 15, recv_idle = 62;
   int          stall_cycles = 0;

   function automatic logic [63:0] q16_square(logic signed [31:0] v);
      logic [63:0] a;
      a = v < 0 ? 64'(-64'(v)) : 64'(v);
      return (a * a) >> 16;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   task automatic clear_run();
      run_cnt = 0; run_lo = 0; run_hi = 0;
      w_id = 0; w_x = 0; w_y = 0; w_z = 0;
      val_sum = 0; sq_sum = 0; hits = 0;
   endtask

   task automatic track_sample(sample_type s);
      logic signed [31:0] v;
      logic signed [48:0] t;
      logic [64:0] q;
      logic signed [63:0] m;
      logic [63:0] ms;
      bit take;
      summary_type r;
      v = s.value;
      if (run_cnt == 0) begin
         run_lo = v; run_hi = v; take = 1;
      end else begin
         take = cfg.largest_is_worst ? (v > run_hi) : (v < run_lo);
         if (v < run_lo) run_lo = v;
         if (v > run_hi) run_hi = v;
      end
      if (take) begin
         w_id = s.id; w_x = s.lx; w_y = s.ly; w_z = s.lz;
      end
      if (run_cnt < CNT_MAX) run_cnt++;
      t = 49'(val_sum) + 49'(v);
      if (t > 49'sh7FFF_FFFF_FFFF) val_sum = 48'sh7FFF_FFFF_FFFF;
      else if (t < -49'sh8000_0000_0000) val_sum = 48'sh8000_0000_0000;
      else val_sum = t[47:0];
      q = 65'(sq_sum) + 65'(q16_square(v));
      sq_sum = q[64] ? '1 : q[63:0];
      if (cfg.warning_enable && v > $signed(cfg.warning_threshold) && hits < CNT_MAX)
         hits++;
      if (!s.last) return;
      m = 64'(val_sum) / $signed(64'(run_cnt));
      if (m > 64'sh7FFF_FFFF) m = 64'sh7FFF_FFFF;
      if (m < -64'sh8000_0000) m = -64'sh8000_0000;
      ms = sq_sum / 64'(run_cnt);
      r.count = 16'(run_cnt); r.min_v = run_lo; r.max_v = run_hi;
      r.worst_id = w_id; r.wx = w_x; r.wy = w_y; r.wz = w_z;
      r.above = 16'(hits); r.mean = m[31:0];
      r.rms = ms >= (64'd1 << 46) ? 31'h7FFF_FFFF : 31'(int_sqrt(ms << 16));
      summary_queue = {summary_queue, r};
      clear_run();
   endtask

   task automatic write_reg(logic [rmstat_pkg::CSR_IDX_BITS-1:0] idx, logic [31:0] d);
      csr_we <= 1; csr_index <= idx; csr_wdata <= d;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         rmstat_pkg::CSR_LARGEST_IS_WORST:  cfg.largest_is_worst = d[0];
         rmstat_pkg::CSR_WARNING_ENABLE:    cfg.warning_enable = d[0];
         rmstat_pkg::CSR_WARNING_THRESHOLD: cfg.warning_threshold = d;
         default: ;
      endcase
   endtask

   task automatic settle();
      req_valid <= 0;
      while (summary_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // hold valid across back-to-back transactions; drop it only while idling
   task automatic drive(sample_type s);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sample_value <= s.value; req_entity_id <= s.id;
      req_loc_x <= s.lx; req_loc_y <= s.ly; req_loc_z <= s.lz;
      req_last_sample <= s.last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send(sample_type s);
      drive(s);
      track_sample(s);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7FFF_FFFF - $urandom_range(3);
         2: return 32'($signed($urandom_range(2000)) - 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic sample_type rand_sample(bit last);
      sample_type s;
      s.value = rand_value();
      s.id = $urandom; s.lx = $urandom; s.ly = $urandom; s.lz = $urandom;
      s.last = last;
      return s;
   endfunction

   // receiver and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (summary_queue.size() == 0) begin
               $error("unexpected summary transaction");
               errors++;
            end else begin
               summary_type e;
               e = summary_queue.pop_front();
               if (rsp_sample_count !== e.count) begin
                  $error("sample_count exp %0d got %0d", e.count, rsp_sample_count); errors++;
               end
               if (rsp_min_value !== e.min_v) begin
                  $error("min_value exp %h got %h", e.min_v, rsp_min_value); errors++;
               end
               if (rsp_max_value !== e.max_v) begin
                  $error("max_value exp %h got %h", e.max_v, rsp_max_value); errors++;
               end
               if (rsp_worst_entity !== e.worst_id) begin
                  $error("worst_entity exp %h got %h", e.worst_id, rsp_worst_entity); errors++;
               end
               if (rsp_worst_x !== e.wx) begin
                  $error("worst_x exp %h got %h", e.wx, rsp_worst_x); errors++;
               end
               if (rsp_worst_y !== e.wy) begin
                  $error("worst_y exp %h got %h", e.wy, rsp_worst_y); errors++;
               end
               if (rsp_worst_z !== e.wz) begin
                  $error("worst_z exp %h got %h", e.wz, rsp_worst_z); errors++;
               end
               if (rsp_above_count !== e.above) begin
                  $error("above_count exp %0d got %0d", e.above, rsp_above_count); errors++;
               end
               if (rsp_mean_value !== e.mean) begin
                  $error("mean_value exp %h got %h", e.mean, rsp_mean_value); errors++;
               end
               if (rsp_rms_value !== e.rms) begin
                  $error("rms_value exp %h got %h", e.rms, rsp_rms_value); errors++;
               end
            end
         end
         rsp_ready <= $urandom_range(99) >= recv_idle;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   row_type table_rows[$];

   task automatic add_row(logic [31:0] v, logic [31:0] id, bit last, bit known,
                          summary_type r);
      row_type w;
      w.s.value = v; w.s.id = id; w.s.lx = ~id; w.s.ly = id ^ 32'h5A5A_5A5A;
      w.s.lz = {id[15:0], id[31:16]}; w.s.last = last;
      w.known = known; w.sum = r;
      table_rows = {table_rows, w};
   endtask

   initial begin
      summary_type r, none;
      int n, len, runs_done;
      none = '{default: '0};
      cfg = '{default: '0};
      clear_run();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // single-item runs at the extremes; summary read off directly
      r = '{count: 1, min_v: 32'h7FFF_FFFF, max_v: 32'h7FFF_FFFF, worst_id: 32'hFFFF_FFFF,
            wx: 32'h0, wy: 32'hA5A5_A5A5, wz: 32'hFFFF_FFFF, above: 0,
            mean: 32'h7FFF_FFFF, rms: 31'h7FFF_FFFE};
      add_row(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, r);
      r = '{count: 1, min_v: 32'h8000_0000, max_v: 32'h8000_0000, worst_id: 32'h0,
            wx: 32'hFFFF_FFFF, wy: 32'h5A5A_5A5A, wz: 32'h0, above: 0,
            mean: 32'h8000_0000, rms: 31'h7FFF_FFFF};
      add_row(32'h8000_0000, 32'h0, 1, 1, r);
      r = '{count: 1, min_v: 0, max_v: 0, worst_id: 32'h1234_5678,
            wx: ~32'h1234_5678, wy: 32'h1234_5678 ^ 32'h5A5A_5A5A, wz: 32'h5678_1234,
            above: 0, mean: 0, rms: 0};
      add_row(32'h0, 32'h1234_5678, 1, 1, r);
      // ties and mixed runs
      add_row(32'h0001_0000, 1, 0, 0, none);
      add_row(32'hFFFF_0000, 2, 0, 0, none);
      add_row(32'hFFFF_0000, 3, 0, 0, none);
      add_row(32'h0001_0000, 4, 1, 0, none);
      add_row(32'h7FFF_FFFF, 5, 0, 0, none);
      add_row(32'h7FFF_FFFF, 6, 0, 0, none);
      add_row(32'h7FFF_FFFF, 7, 1, 0, none);
      add_row(32'h8000_0000, 8, 0, 0, none);
      add_row(32'h8000_0000, 9, 1, 0, none);

      foreach (table_rows[i]) begin
         if (table_rows[i].known) begin
            track_sample(table_rows[i].s);
            summary_queue[summary_queue.size() - 1] = table_rows[i].sum;
            drive(table_rows[i].s);
         end else begin
            send(table_rows[i].s);
         end
      end
      settle();

      // threshold and worst-side settings, directed
      write_reg(rmstat_pkg::CSR_LARGEST_IS_WORST, 1);
      write_reg(rmstat_pkg::CSR_WARNING_ENABLE, 1);
      write_reg(rmstat_pkg::CSR_WARNING_THRESHOLD, 32'h8000_0000);
      for (int i = 0; i < 4; i++) send(rand_sample(i == 3));
      settle();
      write_reg(rmstat_pkg::CSR_WARNING_THRESHOLD, 32'h7FFF_FFFF);
      send(rand_sample(0)); send(rand_sample(1));
      settle();
      write_reg(CSR_UNMAPPED, 32'hFFFF_FFFF);
      send(rand_sample(1));
      settle();

      // random runs in three idling phases
      n = 0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = ph == 0 ? 15 : (ph == 1 ? 62 : 0);
         recv_idle = ph == 0 ? 62 : (ph == 1 ? 15 : 0);
         write_reg(rmstat_pkg::CSR_LARGEST_IS_WORST, $urandom_range(1));
         write_reg(rmstat_pkg::CSR_WARNING_ENABLE, 32'($urandom_range(3) != 0));
         write_reg(rmstat_pkg::CSR_WARNING_THRESHOLD, rand_value());
         runs_done = 0;
         while (n < 430 * (ph + 1) || runs_done < 30) begin
            len = $urandom_range(3) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 24);
            for (int i = 0; i < len; i++) begin
               send(rand_sample(i == len - 1));
               n++;
            end
            runs_done++;
         end
         settle();
      end

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
